// ----- hdl/pipct_pkg.sv -----
// Shared types and constants for the polyline crossing test.
package pipct_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int ADDR_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = ADDR_W + 1;
  localparam int CFG_W = 11;
  localparam int IDX_W = 10;
  localparam int COORD_W = 16;
  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int N_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } vertex_t;

  localparam int VTX_W = $bits(vertex_t);

endpackage

// ----- hdl/pipct_if.sv -----
// Request and result channel interfaces.
interface pipct_in_if import pipct_pkg::*; ;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [IDX_W-1:0]          vertex_index;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;

  modport source (output valid, output opcode, output vertex_index, output point_x,
                  output point_y, input ready);
  modport sink (input valid, input opcode, input vertex_index, input point_x,
                input point_y, output ready);
endinterface

interface pipct_out_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, output inside_res, input ready);
  modport sink (input valid, input inside_res, output ready);
endinterface

// ----- hdl/pipct_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pipct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/point_in_polyline_crossing_test.sv -----
// Top level: vertex table and even-odd crossing test over the stored polyline.
// A vertex write leaves the block idle, so it is ready again for the next request.
// A query walks the edges between consecutive stored vertices (at most 1024 used);
// each edge passes through MUL1, MUL2 and CMP, the first two on one shared 17x17
// multiplier. Under two vertices, no edge is walked; the result waits on port stalls.
// Synchronous active-low reset clears the sequencer, count register and result valid.
module point_in_polyline_crossing_test import pipct_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  pipct_in_if.sink           in_chan,
  pipct_out_if.source        out_chan,
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_wdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIRST = 3'd1;
  localparam logic [2:0] S_MUL1  = 3'd2;
  localparam logic [2:0] S_MUL2  = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]                state_r, state_nxt;
  logic [CFG_W-1:0]          count_r;
  logic [CNT_W-1:0]          n_r, n_nxt;
  logic [ADDR_W-1:0]         cur_idx_r, cur_idx_nxt;
  logic signed [COORD_W-1:0] px_r, py_r;
  vertex_t                   prev_r, cur_r;
  logic signed [PROD_W-1:0]  lhs_r, rhs_r;
  logic                      parity_r, parity_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_inside_r;

  logic                      accept;
  logic                      ram_we, ram_re;
  logic [ADDR_W-1:0]         ram_raddr;
  logic [VTX_W-1:0]          ram_rdata;
  vertex_t                   rd_vtx, b_vtx;
  logic [N_W-1:0]            cnt_ext;
  logic signed [DIFF_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic                      below1, below2, rising, crosses, more;
  logic [CNT_W-1:0]          next_idx;

  assign accept = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.inside_res = out_inside_r;

  assign ram_we = accept && (in_chan.opcode == OP_WRITE) &&
                  (32'(in_chan.vertex_index) < 32'(MAX_VERTICES));
  assign rd_vtx = vertex_t'(ram_rdata);

  pipct_ram #(
    .WIDTH (VTX_W),
    .DEPTH (MAX_VERTICES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(in_chan.vertex_index)),
    .wdata ({in_chan.point_y, in_chan.point_x}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared multiplier: edge's left side first, right side second
  assign b_vtx = (state_r == S_MUL1) ? rd_vtx : cur_r;
  always_comb begin
    if (state_r == S_MUL1) begin
      mul_a = {px_r[COORD_W-1], px_r} - {prev_r.x[COORD_W-1], prev_r.x};
      mul_b = {b_vtx.y[COORD_W-1], b_vtx.y} - {prev_r.y[COORD_W-1], prev_r.y};
    end else begin
      mul_a = {py_r[COORD_W-1], py_r} - {prev_r.y[COORD_W-1], prev_r.y};
      mul_b = {b_vtx.x[COORD_W-1], b_vtx.x} - {prev_r.x[COORD_W-1], prev_r.x};
    end
  end
  assign prod = mul_a * mul_b;

  assign below1 = py_r < prev_r.y;
  assign below2 = py_r < cur_r.y;
  assign rising = cur_r.y > prev_r.y;
  assign crosses = (below1 != below2) && (rising ? (lhs_r < rhs_r) : (lhs_r > rhs_r));
  assign next_idx = CNT_W'(cur_idx_r) + CNT_W'(1);
  assign more = next_idx < n_r;

  assign cnt_ext = N_W'(count_r);
  assign n_nxt = (cnt_ext > N_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : CNT_W'(cnt_ext);

  always_comb begin
    state_nxt = state_r;
    cur_idx_nxt = cur_idx_r;
    parity_nxt = parity_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    ram_re = 1'b0;
    ram_raddr = cur_idx_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_chan.opcode == OP_QUERY)) begin
          parity_nxt = 1'b0;
          cur_idx_nxt = '0;
          if (n_nxt < CNT_W'(2)) begin
            state_nxt = S_FIN;
          end else begin
            ram_re = 1'b1;
            ram_raddr = '0;
            state_nxt = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        ram_re = 1'b1;
        ram_raddr = ADDR_W'(1);
        cur_idx_nxt = ADDR_W'(1);
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        parity_nxt = parity_r ^ crosses;
        if (more) begin
          ram_re = 1'b1;
          ram_raddr = next_idx[ADDR_W-1:0];
          cur_idx_nxt = next_idx[ADDR_W-1:0];
          state_nxt = S_MUL1;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      out_valid_r <= 1'b0;
      parity_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      parity_r <= parity_nxt;
      if (cfg_we) begin
        count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_idx_r <= cur_idx_nxt;
    if (accept && (in_chan.opcode == OP_QUERY)) begin
      px_r <= in_chan.point_x;
      py_r <= in_chan.point_y;
      n_r <= n_nxt;
    end
    if (state_r == S_FIRST) begin
      prev_r <= rd_vtx;
    end
    if (state_r == S_MUL1) begin
      cur_r <= rd_vtx;
      lhs_r <= prod;
    end
    if (state_r == S_MUL2) begin
      rhs_r <= prod;
    end
    if (state_r == S_CMP) begin
      prev_r <= cur_r;
    end
    if ((state_r == S_FIN) && (!out_valid_r || out_chan.ready)) begin
      out_inside_r <= parity_r;
    end
  end

endmodule

// ----- hdl/pipct_checker.sv -----
// Port-level checker for the polyline crossing test, bound to the top level.
module pipct_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_opcode,
  input logic out_valid,
  input logic out_ready
);

  a_reset_clears_result: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result valid after reset");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped while stalled");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_opcode |=> !in_ready) else $error("ready after query request");

  a_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_opcode |=> in_ready) else $error("write request stalled");

  a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready)) else $error("result without query in progress");

endmodule

bind point_in_polyline_crossing_test pipct_checker u_pipct_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .in_opcode (in_chan.opcode),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready)
);
